// File: hdl/nnr_pkg.sv
`timescale 1ns / 1ps

package nnr_pkg;

  // Default depth of the base stack
  localparam int MAX_LEN_DEF = 256;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_FETCH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  // Configuration register indexes
  localparam logic REG_REV_COMP  = 1'b0;
  localparam logic REG_SKIP_DASH = 1'b1;

  // ASCII characters used by the decoder
  localparam logic [7:0] ASC_A    = 8'h41;
  localparam logic [7:0] ASC_C    = 8'h43;
  localparam logic [7:0] ASC_G    = 8'h47;
  localparam logic [7:0] ASC_T    = 8'h54;
  localparam logic [7:0] ASC_N    = 8'h4E;
  localparam logic [7:0] ASC_DASH = 8'h2D;
  localparam logic [7:0] ASC_DOT  = 8'h2E;
  localparam logic [7:0] ASC_SP   = 8'h20;
  localparam logic [7:0] ASC_NUL  = 8'h00;
  localparam logic [7:0] ASC_TAB  = 8'h09;
  localparam logic [7:0] ASC_LF   = 8'h0A;
  localparam logic [7:0] ASC_VT   = 8'h0B;
  localparam logic [7:0] ASC_FF   = 8'h0C;
  localparam logic [7:0] ASC_CR   = 8'h0D;

  // 3-bit base code, as kept in the stack
  typedef enum logic [2:0] {
    CODE_A    = 3'd0,
    CODE_C    = 3'd1,
    CODE_G    = 3'd2,
    CODE_T    = 3'd3,
    CODE_N    = 3'd4,
    CODE_SKIP = 3'd5,
    CODE_BAD  = 3'd6
  } code_t;

  // Character classifier
  function automatic code_t classify(input logic [7:0] ch, input logic skip_dash);
    code_t c;
    case (ch) inside
      8'h41, 8'h61:                 c = CODE_A;   // A a
      8'h43, 8'h63:                 c = CODE_C;   // C c
      8'h47, 8'h67:                 c = CODE_G;   // G g
      8'h54, 8'h74, 8'h55, 8'h75:   c = CODE_T;   // T t U u
      // ambiguity codes R Y S W K M B D H V N, either case
      8'h52, 8'h72, 8'h59, 8'h79, 8'h53, 8'h73, 8'h57, 8'h77,
      8'h4B, 8'h6B, 8'h4D, 8'h6D, 8'h42, 8'h62, 8'h44, 8'h64,
      8'h48, 8'h68, 8'h56, 8'h76, 8'h4E, 8'h6E, ASC_DOT:
                                    c = CODE_N;
      ASC_FF, ASC_CR, ASC_LF, ASC_TAB, ASC_VT, ASC_NUL, ASC_SP:
                                    c = CODE_SKIP;
      ASC_DASH:                     c = skip_dash ? CODE_SKIP : CODE_BAD;
      default:                      c = CODE_BAD;
    endcase
    return c;
  endfunction

  // ASCII of a base code
  function automatic logic [7:0] code_ascii(input logic [2:0] c);
    logic [7:0] a;
    case (c)
      CODE_A:  a = ASC_A;
      CODE_C:  a = ASC_C;
      CODE_G:  a = ASC_G;
      CODE_T:  a = ASC_T;
      default: a = ASC_N;
    endcase
    return a;
  endfunction

  // ASCII of the complement of a stored base code
  function automatic logic [7:0] comp_ascii(input logic [2:0] c);
    logic [7:0] a;
    case (c)
      CODE_A:  a = ASC_T;
      CODE_C:  a = ASC_G;
      CODE_G:  a = ASC_C;
      CODE_T:  a = ASC_A;
      default: a = ASC_N;
    endcase
    return a;
  endfunction

endpackage

// File: hdl/nnr_ram.sv
`timescale 1ns / 1ps

// Single-port synchronous RAM, registered read
module nnr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/nucleotide_normalize_revcomp_unit.sv
`timescale 1ns / 1ps

// Sequence character normalizer with reverse-complement stack.
//
// Input: a transaction is taken when start is high and busy is low. op selects
// a raw character (raw_char), a fetch of the next reversed base, or a clear of
// the stack and the base count. Results appear on base/status/base_count/last
// for exactly one cycle, marked by strobe; the receiver cannot stall them.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 rev_comp, 1 skip_dash)
// and cfg_data; write only while the block is idle.
// Character and clear transactions do not raise busy, and any result strobes
// the cycle after the accept. A fetch from a non-empty stack first enters the
// pop state for the registered stack RAM read; busy is high in that state, and
// the result is registered as the pop state ends. Skipped characters and
// pushes in reverse-complement mode give no result.
// Reset (rst, synchronous): stack and counts empty, both settings zero. The
// stack RAM contents are not cleared; only entries below the count are read.

module nucleotide_normalize_revcomp_unit #(
  parameter int MAX_LEN = nnr_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input transactions
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op,
  input  logic [7:0] raw_char,
  // results
  output logic       strobe,
  output logic [7:0] base,
  output logic [1:0] status,
  output logic [15:0] base_count,
  output logic       last,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic       cfg_data
);

  import nnr_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  state_t         state;
  logic           rev_comp;
  logic           skip_dash;
  logic [CW-1:0]  stored_count;
  logic [15:0]    accepted_count;

  logic           accept;
  code_t          code;
  logic           is_empty;
  logic           is_full;
  logic [CW-1:0]  count_dec;
  logic [15:0]    acc_inc;
  logic           push;
  logic           pop;
  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [2:0]     ram_rdata;

  // Decode and stack control
  assign busy      = (state == ST_POP);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;
  assign code      = classify(raw_char, skip_dash);
  assign is_empty  = (stored_count == '0);
  assign is_full   = (stored_count == CW'(MAX_LEN));
  assign count_dec = stored_count - CW'(1);
  assign acc_inc   = (accepted_count == 16'hFFFF) ? accepted_count : accepted_count + 16'd1;

  assign push = accept && (op == OP_CHAR) && rev_comp && !is_full &&
                (code != CODE_SKIP) && (code != CODE_BAD);
  assign pop  = accept && (op == OP_FETCH) && !is_empty;

  assign ram_we   = push;
  assign ram_addr = pop ? count_dec[AW-1:0] : stored_count[AW-1:0];

  nnr_ram #(
    .WIDTH (3),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (code),
    .rdata (ram_rdata)
  );

  // State, counts, settings and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      strobe         <= 1'b0;
      rev_comp       <= 1'b0;
      skip_dash      <= 1'b0;
      stored_count   <= '0;
      accepted_count <= '0;
    end else begin
      strobe <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REV_COMP:  rev_comp  <= cfg_data;
          REG_SKIP_DASH: skip_dash <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_CHAR: begin
                if (code == CODE_BAD) begin
                  strobe     <= 1'b1;
                  base       <= '0;
                  status     <= STAT_INVALID;
                  base_count <= accepted_count;
                  last       <= 1'b0;
                end else if (code != CODE_SKIP) begin
                  if (!rev_comp) begin
                    accepted_count <= acc_inc;
                    strobe         <= 1'b1;
                    base           <= code_ascii(code);
                    status         <= STAT_OK;
                    base_count     <= acc_inc;
                    last           <= 1'b0;
                  end else if (is_full) begin
                    strobe     <= 1'b1;
                    base       <= '0;
                    status     <= STAT_FULL;
                    base_count <= accepted_count;
                    last       <= 1'b0;
                  end else begin
                    stored_count   <= stored_count + CW'(1);
                    accepted_count <= acc_inc;
                  end
                end
              end
              OP_FETCH: begin
                if (is_empty) begin
                  strobe     <= 1'b1;
                  base       <= '0;
                  status     <= STAT_EMPTY;
                  base_count <= accepted_count;
                  last       <= 1'b0;
                end else begin
                  stored_count <= count_dec;
                  state        <= ST_POP;
                end
              end
              OP_CLEAR: begin
                stored_count   <= '0;
                accepted_count <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_POP: begin
          // RAM data of the popped entry is valid now
          strobe     <= 1'b1;
          base       <= comp_ascii(ram_rdata);
          status     <= STAT_OK;
          base_count <= accepted_count;
          last       <= is_empty;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe && (status == STAT_OK))
    else $error("pop did not produce a result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CW'(MAX_LEN))
    else $error("stack count beyond depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == STAT_FULL) |-> is_full)
    else $error("full reported with room left");

  // last holds between results; only a strobed last counts
  a_last_empty: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> is_empty && (status == STAT_OK))
    else $error("last flagged with bases still stored");

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(push && pop))
    else $error("push and pop in one cycle");

endmodule
